// ===== hdl/utf_to_oem_transcoder_macros.svh =====
// Assertion macros for the code-page transcoder.
// Used by the top level only; needs clk and arst_n in scope.
`ifndef UTF_TO_OEM_TRANSCODER_MACROS_SVH
`define UTF_TO_OEM_TRANSCODER_MACROS_SVH
// implication checked on every clock, off during reset
`define UOT_ASSERT_IMPL(label, lhs, rhs, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (lhs) |-> (rhs)) else $error(msg);
// next-cycle implication
`define UOT_ASSERT_NEXT(label, lhs, rhs, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (lhs) |=> (rhs)) else $error(msg);
`endif

// ===== hdl/uot_pkg.sv =====
// Package for the code-page transcoder: types, constants, table lookup.
// No dependencies.
`default_nettype none
package uot_pkg;
	localparam logic [7:0] QMARK = 8'h3F;

	// work item passed from decoder to mapper
	typedef struct packed {
		logic        qmark;
		logic [15:0] cp;
	} cp_item_t;

	typedef logic [15:0] tbl_t [256];
	localparam tbl_t OEM_TABLE = '{
	16'hF000,16'hF001,16'h2190,16'h2192,16'h2191,16'h2193,16'h25C0,16'h25B6,
	16'hF008,16'hF009,16'hF00A,16'hF00B,16'hF00C,16'hF00D,16'h2023,16'h2022,
	16'h0394,16'h03C0,16'h03A3,16'h03A9,16'h2248,16'h221A,16'hF016,16'hF017,
	16'hF018,16'hF019,16'hF01A,16'hF01B,16'hF01C,16'hF01D,16'hF01E,16'hF01F,
	16'h0020,16'h0021,16'h0022,16'h0023,16'h0024,16'h0025,16'h0026,16'h0027,
	16'h0028,16'h0029,16'h002A,16'h002B,16'h002C,16'h002D,16'h002E,16'h002F,
	16'h0030,16'h0031,16'h0032,16'h0033,16'h0034,16'h0035,16'h0036,16'h0037,
	16'h0038,16'h0039,16'h003A,16'h003B,16'h003C,16'h003D,16'h003E,16'h003F,
	16'h0040,16'h0041,16'h0042,16'h0043,16'h0044,16'h0045,16'h0046,16'h0047,
	16'h0048,16'h0049,16'h004A,16'h004B,16'h004C,16'h004D,16'h004E,16'h004F,
	16'h0050,16'h0051,16'h0052,16'h0053,16'h0054,16'h0055,16'h0056,16'h0057,
	16'h0058,16'h0059,16'h005A,16'h005B,16'h005C,16'h005D,16'h005E,16'h005F,
	16'h0060,16'h0061,16'h0062,16'h0063,16'h0064,16'h0065,16'h0066,16'h0067,
	16'h0068,16'h0069,16'h006A,16'h006B,16'h006C,16'h006D,16'h006E,16'h006F,
	16'h0070,16'h0071,16'h0072,16'h0073,16'h0074,16'h0075,16'h0076,16'h0077,
	16'h0078,16'h0079,16'h007A,16'h007B,16'h007C,16'h007D,16'h007E,16'hF07F,
	16'hF080,16'hF081,16'hF082,16'hF083,16'hF084,16'hF085,16'hF086,16'hF087,
	16'hF088,16'hF089,16'hF08A,16'hF08B,16'hF08C,16'hF08D,16'hF08E,16'hF08F,
	16'h2500,16'h2502,16'h253C,16'h254B,16'h2524,16'h251C,16'h2534,16'h252C,
	16'h252B,16'h2523,16'h253B,16'h2533,16'h2518,16'h2514,16'h2510,16'h250C,
	16'hF0A0,16'h00A1,16'hF0A2,16'h00A3,16'h20AC,16'h00A5,16'hF0A6,16'hF0A7,
	16'hF0A8,16'hF0A9,16'hF0AA,16'hF0AB,16'hF0AC,16'hF0AD,16'hF0AE,16'hF0AF,
	16'h00B0,16'h00B1,16'h00B2,16'h00B3,16'hF0B4,16'h00B5,16'hF0B6,16'hF0B7,
	16'hF0B8,16'h00B9,16'hF0BA,16'hF0BB,16'hF0BC,16'hF0BD,16'hF0BE,16'h00BF,
	16'h00C0,16'h00C1,16'h00C2,16'h00C3,16'h00C4,16'h00C5,16'h00C6,16'h00C7,
	16'h00C8,16'h00C9,16'h00CA,16'h00CB,16'h00CC,16'h00CD,16'h00CE,16'h00CF,
	16'h00D0,16'h00D1,16'h00D2,16'h00D3,16'h00D4,16'h00D5,16'h00D6,16'h00D7,
	16'h00D8,16'h00D9,16'h00DA,16'h00DB,16'h00DC,16'h00DD,16'h00DE,16'h00DF,
	16'h00E0,16'h00E1,16'h00E2,16'h00E3,16'h00E4,16'h00E5,16'h00E6,16'h00E7,
	16'h00E8,16'h00E9,16'h00EA,16'h00EB,16'h00EC,16'h00ED,16'h00EE,16'h00EF,
	16'h00F0,16'h00F1,16'h00F2,16'h00F3,16'h00F4,16'h00F5,16'h00F6,16'h00F7,
	16'h00F8,16'h00F9,16'h00FA,16'h00FB,16'h00FC,16'h00FD,16'h00FE,16'h221E};

	// full code mapping; first matching table index wins
	function automatic logic [7:0] map_code(input cp_item_t it);
		logic [15:0] cp;
		logic [7:0]  r;
		logic        hit;
		cp  = (it.cp == 16'h000A) ? 16'h000D : it.cp;
		r   = QMARK;
		hit = 1'b0;
		for (int i = 0; i < 256; i++) begin
			if (!hit && OEM_TABLE[i] == cp) begin
				r   = 8'(i);
				hit = 1'b1;
			end
		end
		if (it.qmark || cp == 16'hFFFF)
			r = QMARK;
		else if ((cp >= 16'h0020 && cp <= 16'h007E) || cp == 16'h000D)
			r = cp[7:0];
		return r;
	endfunction
endpackage
`default_nettype wire

// ===== hdl/uot_stream_if.sv =====
// Valid/ready stream interface, payload width set by parameter.
// No dependencies.
`default_nettype none
interface uot_stream_if #(parameter int W = 8) ();
	logic         valid;
	logic         ready;
	logic [W-1:0] data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== hdl/uot_front.sv =====
// Front end: UTF-8/UTF-16 decoder producing code points or error marks.
// Depends on uot_pkg.
`default_nettype none
module uot_front import uot_pkg::*; (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     utf16,
	input  wire logic     clr,
	input  wire logic     in_fire,
	input  wire logic [15:0] unit,
	output cp_item_t      item,
	output logic          emit
);
	logic [1:0]  pend_q;
	logic [20:0] part_q;
	logic        hs_q;
	logic [1:0]  pend_d;
	logic [20:0] part_d;
	logic        hs_d;
	logic [7:0]  b;
	logic        is_hi, is_lo;
	logic [20:0] acc;
	logic [20:0] pair;

	assign b     = unit[7:0];
	assign is_hi = unit[15:10] == 6'b110110;
	assign is_lo = unit[15:10] == 6'b110111;
	assign acc   = {part_q[14:0], b[5:0]};
	assign pair  = 21'h10000 + {1'b0, part_q[9:0], unit[9:0]};

	// decode step
	always_comb begin
		pend_d = pend_q; part_d = part_q; hs_d = hs_q;
		emit = 1'b0; item.qmark = 1'b0; item.cp = 16'h0;
		if (utf16) begin
			if (hs_q) begin
				pend_d = 2'd0; part_d = '0; hs_d = 1'b0; emit = 1'b1;
				item.qmark = !is_lo || pair[20:16] != 5'd0;
				item.cp = pair[15:0];
			end else if (is_hi) begin
				part_d = {11'd0, unit[9:0]}; hs_d = 1'b1;
			end else begin
				emit = 1'b1; item.qmark = is_lo; item.cp = unit;
			end
		end else if (pend_q != 2'd0) begin
			emit = 1'b1;
			if (b[7:6] != 2'b10) begin
				pend_d = 2'd0; part_d = '0; hs_d = 1'b0; item.qmark = 1'b1;
			end else begin
				pend_d = pend_q - 2'd1;
				if (pend_q != 2'd1) begin
					part_d = acc; emit = 1'b0;
				end else begin
					part_d = '0;
					item.qmark = acc[20:16] != 5'd0;
					item.cp = acc[15:0];
				end
			end
		end else if (b < 8'h80) begin
			emit = 1'b1; item.cp = {8'h00, b};
		end else if (b < 8'hC0 || b > 8'hF7) begin
			emit = 1'b1; item.qmark = 1'b1;
		end else if (b < 8'hE0) begin
			part_d = {16'd0, b[4:0]}; pend_d = 2'd1;
		end else if (b < 8'hF0) begin
			part_d = {17'd0, b[3:0]}; pend_d = 2'd2;
		end else begin
			part_d = {18'd0, b[2:0]}; pend_d = 2'd3;
		end
	end

	// decoder state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= '0; part_q <= '0; hs_q <= 1'b0;
		end else if (clr) begin
			pend_q <= '0; part_q <= '0; hs_q <= 1'b0;
		end else if (in_fire) begin
			pend_q <= pend_d; part_q <= part_d; hs_q <= hs_d;
		end
	end
endmodule
`default_nettype wire

// ===== hdl/uot_back.sv =====
// Back end: two-entry queue of decoded items, table mapping, output register.
// Depends on uot_pkg.
`default_nettype none
module uot_back import uot_pkg::*; (
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  push,
	input  cp_item_t   item,
	output logic       has_room,
	output logic       out_valid,
	input  wire logic  out_ready,
	output logic [7:0] out_data
);
	cp_item_t   fifo_q [2];
	logic       wp_q, rp_q;
	logic [1:0] cnt_q;
	logic       ov_q;
	logic [7:0] od_q;
	logic       pop;

	assign has_room  = cnt_q != 2'd2;
	assign out_valid = ov_q;
	assign out_data  = od_q;
	assign pop       = cnt_q != 2'd0 && (!ov_q || out_ready);

	always_ff @(posedge clk) begin
		if (push) fifo_q[wp_q] <= item;
		if (pop) od_q <= map_code(fifo_q[rp_q]);
	end

	// queue pointers and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= 1'b0; rp_q <= 1'b0; cnt_q <= '0; ov_q <= 1'b0;
		end else begin
			if (push) wp_q <= !wp_q;
			if (pop) rp_q <= !rp_q;
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
			if (pop) ov_q <= 1'b1;
			else if (out_ready) ov_q <= 1'b0;
		end
	end
endmodule
`default_nettype wire

// ===== hdl/utf_to_oem_transcoder.sv =====
// UTF-8/UTF-16 to 8-bit code page transcoder, top level.
// Channels: in_ch carries code_unit (16 bits), out_ch carries oem_code (8 bits),
// cfg_ch writes input_is_utf16. All are valid/ready; transfer when both high.
// One code unit accepted per cycle while the queue has room; a finished
// character is written into the queue, then table-mapped into the output
// register. Sustained rate is one item per cycle while out_ch is ready,
// set by the combinational decoder step and the back-end table compare.
// The two-entry queue between decoder and mapper lets input keep flowing
// while the output register waits; when the receiver stalls the queue fills
// and in_ch.ready drops.
// Reset clears the mode to UTF-8, the decoder state, queue and output valid.
// A configuration write clears the decoder state; cfg_ch is always ready.
// Units that only extend a sequence produce no output item.
`default_nettype none
`include "utf_to_oem_transcoder_macros.svh"
module utf_to_oem_transcoder import uot_pkg::*; (
	input wire logic    clk,
	input wire logic    arst_n,
	uot_stream_if.sink   in_ch,
	uot_stream_if.sink   cfg_ch,
	uot_stream_if.source out_ch
);
	logic     mode_q;
	logic     room, emit, in_fire, cfg_fire;
	cp_item_t item;

	assign in_ch.ready  = room;
	assign cfg_ch.ready = 1'b1;
	assign in_fire      = in_ch.valid && room;
	assign cfg_fire     = cfg_ch.valid;

	// mode register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) mode_q <= 1'b0;
		else if (cfg_fire) mode_q <= cfg_ch.data[0];
	end

	uot_front u_front (
		.clk, .arst_n, .utf16(mode_q), .clr(cfg_fire), .in_fire,
		.unit(in_ch.data[15:0]), .item, .emit
	);

	uot_back u_back (
		.clk, .arst_n, .push(in_fire && emit), .item, .has_room(room),
		.out_valid(out_ch.valid), .out_ready(out_ch.ready), .out_data(out_ch.data[7:0])
	);

	`UOT_ASSERT_NEXT(a_hold, out_ch.valid && !out_ch.ready, out_ch.valid, "output item dropped")
	`UOT_ASSERT_IMPL(a_room, !in_ch.ready, out_ch.valid, "input stalled with empty output")
	`UOT_ASSERT_NEXT(a_cfg, cfg_ch.valid, mode_q == $past(cfg_ch.data[0]), "mode not written")
endmodule
`default_nettype wire

// ===== sim/utf_to_oem_transcoder_test.sv =====
// Self-checking test of the UTF-8/UTF-16 to code-page transcoder.
// Needs uot_pkg, uot_stream_if and utf_to_oem_transcoder from the hdl folder.
`default_nettype none
module utf_to_oem_transcoder_test;
	import uot_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CYCLE_LIMIT = 400000;
	localparam int DRAIN_CYCLES = 8;
	localparam logic MODE_UTF8 = 1'b0;
	localparam logic MODE_UTF16 = 1'b1;
	localparam logic [15:0] NO_CHECK = 16'hFFFF;

	logic clk;
	logic arst_n;
	uot_stream_if #(.W(16)) in_ch ();
	uot_stream_if #(.W(1)) cfg_ch ();
	uot_stream_if #(.W(8)) out_ch ();

	utf_to_oem_transcoder u_top (
		.clk(clk), .arst_n(arst_n), .in_ch(in_ch), .cfg_ch(cfg_ch), .out_ch(out_ch)
	);

	// code-page table, same content as the block's constant table
	logic [15:0] page_tbl [256];
	// decoder copy
	logic        mode_utf16;
	logic [1:0]  cont_left;
	logic [20:0] cp_acc;
	logic        hi_wait;

	logic [7:0] oem_expected [$];
	int errors;
	int cycles;
	int units_sent;
	int chars_seen;
	int send_idle_pct;
	int recv_idle_pct;

	// clock and cycle guard
	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	function automatic logic [7:0] oem_of(input logic [20:0] cp_in);
		logic [20:0] cp;
		cp = (cp_in == 21'h0A) ? 21'h0D : cp_in;
		if ((cp >= 21'h20 && cp <= 21'h7E) || cp == 21'h0D) return cp[7:0];
		if (cp >= 21'hFFFF) return QMARK;
		for (int i = 0; i < 256; i++)
			if ({5'd0, page_tbl[i]} == cp) return 8'(i);
		return QMARK;
	endfunction

	// decode one unit; push a code-page byte when a character finishes
	task automatic decode_unit(input logic [15:0] u);
		logic [7:0]  b;
		logic        is_hi;
		logic        is_lo;
		logic [9:0]  hi10;
		b = u[7:0];
		is_hi = (u >= 16'hD800 && u <= 16'hDBFF);
		is_lo = (u >= 16'hDC00 && u <= 16'hDFFF);
		if (!mode_utf16) begin
			if (cont_left != 2'd0) begin
				if (b[7:6] != 2'b10) begin
					cont_left = 2'd0; cp_acc = '0;
					oem_expected.push_back(QMARK);
				end else begin
					cp_acc = {cp_acc[14:0], b[5:0]};
					cont_left = cont_left - 2'd1;
					if (cont_left == 2'd0) begin
						oem_expected.push_back(oem_of(cp_acc));
						cp_acc = '0;
					end
				end
			end else if (b < 8'h80) begin
				oem_expected.push_back(oem_of({13'd0, b}));
			end else if (b < 8'hC0 || b > 8'hF7) begin
				oem_expected.push_back(QMARK);
			end else if (b < 8'hE0) begin
				cp_acc = {16'd0, b[4:0]}; cont_left = 2'd1;
			end else if (b < 8'hF0) begin
				cp_acc = {17'd0, b[3:0]}; cont_left = 2'd2;
			end else begin
				cp_acc = {18'd0, b[2:0]}; cont_left = 2'd3;
			end
		end else begin
			if (hi_wait) begin
				hi10 = cp_acc[9:0];
				hi_wait = 1'b0; cp_acc = '0; cont_left = 2'd0;
				oem_expected.push_back(is_lo ? oem_of(21'h10000 + {1'b0, hi10, u[9:0]})
					: QMARK);
			end else if (is_hi) begin
				cp_acc = {11'd0, u[9:0]}; hi_wait = 1'b1;
			end else if (is_lo) begin
				oem_expected.push_back(QMARK);
			end else begin
				oem_expected.push_back(oem_of({5'd0, u}));
			end
		end
	endtask

	task automatic report_mismatch(input string what);
		errors++;
		$display("[%0d] mismatch: %s", cycles, what);
	endtask

	// output check and receiver stalls
	always @(posedge clk) begin
		if (arst_n && out_ch.valid && out_ch.ready) begin
			chars_seen++;
			if (oem_expected.size() == 0)
				report_mismatch($sformatf("unexpected oem_code %h", out_ch.data));
			else begin
				if (out_ch.data !== oem_expected[0])
					report_mismatch($sformatf("oem_code %h, wanted %h",
						out_ch.data, oem_expected[0]));
				void'(oem_expected.pop_front());
			end
		end
	end

	always @(negedge clk)
		out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);

	// valid stays high after an accept when the next unit follows at once
	task automatic send_unit(input logic [15:0] u, input logic [15:0] want);
		int sz;
		while ($urandom_range(99) < send_idle_pct) begin
			in_ch.valid <= 1'b0;
			@(negedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.data <= u;
		do @(posedge clk); while (!in_ch.ready);
		sz = oem_expected.size();
		decode_unit(u);
		units_sent++;
		if (want != NO_CHECK && (oem_expected.size() != sz + 1 ||
				oem_expected[$] != want[7:0]))
			report_mismatch($sformatf("table row %h predicts wrongly", u));
		@(negedge clk);
	endtask

	task automatic settle;
		in_ch.valid <= 1'b0;
		while (oem_expected.size() != 0) @(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	// idle-only register write; clears decoder state
	task automatic write_mode(input logic m);
		settle();
		cfg_ch.valid <= 1'b1;
		cfg_ch.data <= m;
		do @(posedge clk); while (!cfg_ch.ready);
		mode_utf16 = m; cont_left = 2'd0; cp_acc = '0; hi_wait = 1'b0;
		@(negedge clk);
		cfg_ch.valid <= 1'b0;
	endtask

	typedef struct {
		logic        mode;
		logic [15:0] unit;
		logic [15:0] want;
	} stim_row_t;

	stim_row_t dir_rows [] = '{
		'{MODE_UTF8, 16'h0041, 16'h0041}, '{MODE_UTF8, 16'hFF0A, 16'h000D},
		'{MODE_UTF8, 16'h0000, 16'h003F}, '{MODE_UTF8, 16'h007F, 16'h003F},
		'{MODE_UTF8, 16'h0080, 16'h003F}, '{MODE_UTF8, 16'h00F8, 16'h003F},
		'{MODE_UTF8, 16'h00FF, 16'h003F}, '{MODE_UTF8, 16'h00C3, NO_CHECK},
		'{MODE_UTF8, 16'h00A9, NO_CHECK}, '{MODE_UTF8, 16'h00E2, NO_CHECK},
		'{MODE_UTF8, 16'h0082, NO_CHECK}, '{MODE_UTF8, 16'h00AC, NO_CHECK},
		'{MODE_UTF8, 16'h00E2, NO_CHECK}, '{MODE_UTF8, 16'h0041, 16'h003F},
		'{MODE_UTF8, 16'h00F0, NO_CHECK}, '{MODE_UTF8, 16'h009F, NO_CHECK},
		'{MODE_UTF8, 16'h0098, NO_CHECK}, '{MODE_UTF8, 16'h0080, 16'h003F},
		'{MODE_UTF16, 16'hD800, NO_CHECK}, '{MODE_UTF16, 16'hDFFF, 16'h003F},
		'{MODE_UTF16, 16'hDC00, 16'h003F}, '{MODE_UTF16, 16'hDBFF, NO_CHECK},
		'{MODE_UTF16, 16'h0042, 16'h003F}, '{MODE_UTF16, 16'hFFFF, 16'h003F},
		'{MODE_UTF16, 16'h221E, 16'h00FF}
	};

	// random UTF-8: mostly well-formed characters, some noise
	task automatic rand_utf8_char;
		int kind;
		logic [20:0] cp;
		kind = $urandom_range(9);
		if (kind >= 8) begin
			send_unit(16'($urandom()), NO_CHECK);
			return;
		end
		case (kind % 4)
			0: cp = 21'($urandom_range(16'h7F));
			1: cp = 21'($urandom_range(11'h7FF, 8'h80));
			2: cp = (kind < 4) ? {5'd0, page_tbl[8'($urandom_range(255))]}
				: 21'($urandom_range(16'hFFFF, 16'h800));
			default: cp = 21'($urandom_range(21'h1FFFFF));
		endcase
		if (cp < 21'h80) send_unit({8'($urandom()), cp[7:0]}, NO_CHECK);
		else if (cp < 21'h800) begin
			send_unit({8'($urandom()), 3'b110, cp[10:6]}, NO_CHECK);
			send_unit({8'($urandom()), 2'b10, cp[5:0]}, NO_CHECK);
		end else if (cp < 21'h10000) begin
			send_unit({8'($urandom()), 4'hE, cp[15:12]}, NO_CHECK);
			send_unit({8'($urandom()), 2'b10, cp[11:6]}, NO_CHECK);
			if ($urandom_range(15) != 0)
				send_unit({8'($urandom()), 2'b10, cp[5:0]}, NO_CHECK);
		end else begin
			send_unit({8'($urandom()), 5'b11110, cp[20:18]}, NO_CHECK);
			send_unit({8'($urandom()), 2'b10, cp[17:12]}, NO_CHECK);
			send_unit({8'($urandom()), 2'b10, cp[11:6]}, NO_CHECK);
			send_unit({8'($urandom()), 2'b10, cp[5:0]}, NO_CHECK);
		end
	endtask

	task automatic rand_utf16_char;
		int kind;
		kind = $urandom_range(9);
		if (kind < 3) send_unit(page_tbl[8'($urandom_range(255))], NO_CHECK);
		else if (kind < 5) send_unit(16'($urandom_range(16'h7F)), NO_CHECK);
		else if (kind < 7) begin
			send_unit(16'hD800 | 16'($urandom_range(10'h3FF)), NO_CHECK);
			send_unit(16'hDC00 | 16'($urandom_range(10'h3FF)), NO_CHECK);
		end else send_unit(16'($urandom()), NO_CHECK);
	endtask

	initial begin
		page_tbl = OEM_TABLE;
		errors = 0; cycles = 0; units_sent = 0; chars_seen = 0;
		send_idle_pct = 31; recv_idle_pct = 86;
		mode_utf16 = MODE_UTF8; cont_left = 2'd0; cp_acc = '0; hi_wait = 1'b0;
		arst_n = 1'b0;
		in_ch.valid = 1'b0; in_ch.data = '0;
		cfg_ch.valid = 1'b0; cfg_ch.data = '0;
		out_ch.ready = 1'b0;
		repeat (8) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// directed rows, mode switched where a row asks for it
		foreach (dir_rows[i]) begin
			if (dir_rows[i].mode != mode_utf16) write_mode(dir_rows[i].mode);
			send_unit(dir_rows[i].unit, dir_rows[i].want);
		end

		// random phases over both modes and three idle profiles
		for (int ph = 0; ph < 6; ph++) begin
			send_idle_pct = (ph < 2) ? 31 : (ph < 4) ? 86 : 0;
			recv_idle_pct = (ph < 2) ? 86 : (ph < 4) ? 31 : 0;
			write_mode(ph[0]);
			for (int n = 0; n < 200; n++)
				if (ph[0]) rand_utf16_char(); else rand_utf8_char();
		end
		write_mode(MODE_UTF8);
		settle();

		$display("sent %0d code units, checked %0d code-page bytes", units_sent, chars_seen);
		$display("both decode modes, malformed input and three idle profiles covered");
		if (errors == 0 && oem_expected.size() == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end
endmodule
`default_nettype wire

// ===== sim.f =====
+incdir+hdl
hdl/uot_pkg.sv
hdl/uot_stream_if.sv
hdl/uot_front.sv
hdl/uot_back.sv
hdl/utf_to_oem_transcoder.sv
sim/utf_to_oem_transcoder_test.sv
